@@ src/sync_length_crc16_frame_builder_defines.svh @@
// Assertion macros shared by the frame builder RTL.
`ifndef SYNC_LENGTH_CRC16_FRAME_BUILDER_DEFINES_SVH
`define SYNC_LENGTH_CRC16_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcf: next-cycle check failed");

`endif

@@ src/slcf_pkg.sv @@
package slcf_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  LEN_EXTRA   = 8'd3;
  localparam logic [7:0]  MAX_PAYLOAD = 8'd252;

  // Output sequence of one transaction's results
  typedef enum logic [2:0] {
    PH_SYNC,
    PH_LEN,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // Work handed from the CRC stage to the emitter
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  len_code;
    logic [15:0] crc;
    logic        hdr;
    logic        trl;
  } item_t;

  // CRC-16/MODBUS update by one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/slcf_if.sv @@
interface slcf_in_if import slcf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] payload_length;

  modport source (output valid, output payload_byte, output payload_length, input ready);
  modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface

interface slcf_out_if import slcf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

@@ src/slcf_emit.sv @@
`include "sync_length_crc16_frame_builder_defines.svh"

module slcf_emit import slcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  item_t             item,
  output logic              can_take,
  slcf_out_if.source        out_ch
);

  item_t      pend_r;
  logic       pend_valid_r;
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_end_r;

  logic       out_load;
  logic       pend_done;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign out_load  = pend_valid_r && (!out_valid_r || out_ch.ready);
  assign pend_done = out_load && cur_last;
  assign can_take  = !pend_valid_r || pend_done;

  always_comb begin
    cur_byte  = pend_r.data;
    cur_last  = 1'b0;
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_SYNC: begin
        cur_byte  = SYNC_BYTE;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        cur_byte  = pend_r.len_code;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        cur_byte  = pend_r.data;
        cur_last  = !pend_r.trl;
        phase_nxt = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        cur_byte  = pend_r.crc[7:0];
        phase_nxt = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        cur_byte  = pend_r.crc[15:8];
        cur_last  = 1'b1;
      end
      default: begin
        cur_last  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      phase_r      <= PH_SYNC;
    end else if (item_valid) begin
      pend_valid_r <= 1'b1;
      phase_r      <= item.hdr ? PH_SYNC : PH_DATA;
    end else if (pend_done) begin
      pend_valid_r <= 1'b0;
    end else if (out_load) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      pend_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= cur_byte;
      out_end_r  <= (phase_r == PH_CRC_HI);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_end  = out_end_r;

  `SLCF_ASSERT_IMP(a_no_overrun, clk, rst_n, item_valid, can_take)
  `SLCF_ASSERT_IMP(a_hdr_phases, clk, rst_n,
                   pend_valid_r && !pend_r.hdr, phase_r != PH_SYNC && phase_r != PH_LEN)
  `SLCF_ASSERT_IMP(a_trl_phases, clk, rst_n,
                   pend_valid_r && !pend_r.trl, phase_r != PH_CRC_LO && phase_r != PH_CRC_HI)

endmodule

@@ src/sync_length_crc16_frame_builder.sv @@
// Length-prefixed frame builder with a CRC-16/MODBUS trailer.
// in_ch takes one payload byte per transaction with the payload length of its
// frame. out_ch gives the framed stream one byte per transaction: 0xAA, the
// length byte (length + 3), the payload, then CRC low and CRC high, with
// frame_end set on CRC high only. The CRC covers the length byte and payload.
// A frame longer than 252 bytes is consumed and gives nothing; a length of 0
// abandons any partial frame without a trailer.
// The first byte of an input transaction passes the emit slot and then the
// output register before it is offered on out_ch. Each input transaction is
// held in one emit slot and streamed out one byte per cycle unless out_ch
// stalls, so an input is taken every cycle while frames run mid-payload; the
// first byte of a frame emits sync, length and data, the last byte data, CRC
// low and CRC high (all five for a one-byte frame). The emit slot reloads in
// the same cycle as its last byte moves to the output register.
// Reset (rst_n low, synchronous) empties the slot and output register and
// returns the CRC to 0xFFFF and the byte count to 0.
// When the receiver stalls, the output register holds its byte, the slot
// fills, and in_ch.ready drops until the slot drains.
`include "sync_length_crc16_frame_builder_defines.svh"

module sync_length_crc16_frame_builder import slcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  slcf_in_if.sink     in_ch,
  slcf_out_if.source  out_ch
);

  logic [15:0] running_crc_r;
  logic [15:0] running_crc_nxt;
  logic [7:0]  byte_position_r;
  logic [7:0]  byte_position_nxt;

  logic        in_fire;
  logic        can_take;
  logic        len_zero;
  logic        last;
  logic        over;
  logic        first;
  logic [7:0]  len_code;
  logic [15:0] crc_seed;
  logic [15:0] crc_new;
  logic        item_valid;
  item_t       item;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign len_zero = (in_ch.payload_length == 8'd0);
  assign over     = (in_ch.payload_length > MAX_PAYLOAD);
  assign first    = (byte_position_r == 8'd0);
  // frame ends once the count reaches or passes this byte's length
  assign last     = (({1'b0, byte_position_r} + 9'd1) >= {1'b0, in_ch.payload_length});
  assign len_code = in_ch.payload_length + LEN_EXTRA;

  // start a frame from the length byte's CRC, else carry on
  assign crc_seed = first ? crc_byte(CRC_INIT, len_code) : running_crc_r;
  assign crc_new  = crc_byte(crc_seed, in_ch.payload_byte);

  always_comb begin
    running_crc_nxt   = running_crc_r;
    byte_position_nxt = byte_position_r;
    if (len_zero || last) begin
      running_crc_nxt   = CRC_INIT;
      byte_position_nxt = 8'd0;
    end else begin
      byte_position_nxt = byte_position_r + 8'd1;
      if (!over) begin
        running_crc_nxt = crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r   <= CRC_INIT;
      byte_position_r <= 8'd0;
    end else if (in_fire) begin
      running_crc_r   <= running_crc_nxt;
      byte_position_r <= byte_position_nxt;
    end
  end

  // dropped and zero-length transactions update state only
  assign item_valid    = in_fire && !len_zero && !over;
  assign item.data     = in_ch.payload_byte;
  assign item.len_code = len_code;
  assign item.crc      = crc_new;
  assign item.hdr      = first;
  assign item.trl      = last;

  assign in_ch.ready = can_take;

  slcf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .can_take   (can_take),
    .out_ch     (out_ch)
  );

  `SLCF_ASSERT_IMP(a_idle_crc, clk, rst_n,
                   byte_position_r == 8'd0, running_crc_r == CRC_INIT)
  `SLCF_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, byte_position_r != 8'hFF)
  `SLCF_ASSERT_NXT(a_zero_len_clears, clk, rst_n,
                   in_fire && len_zero, byte_position_r == 8'd0)

endmodule
